[hdl/rpn_pkg.sv]
// Package for the RPN stack calculator: token kinds, status codes, sequencer states.
// No dependencies.
package rpn_pkg;
    typedef enum logic [2:0] {
        K_PUSH = 3'd0, K_ADD = 3'd1, K_SUB = 3'd2, K_MUL = 3'd3,
        K_DIV = 3'd4, K_PRINT = 3'd5, K_CLEAR = 3'd6, K_BAD = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_OVERFLOW = 3'd1, ST_UNDERFLOW = 3'd2, ST_EMPTY = 3'd3,
        ST_BADOP = 3'd4, ST_SAT = 3'd5
    } t_status;

    // shift command for the cell row
    typedef enum logic [1:0] {
        SH_HOLD = 2'd0, SH_PUSH = 2'd1, SH_POP = 2'd2, SH_ROT = 2'd3
    } t_shift;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DIV, S_WRITE, S_PRINT, S_OUT
    } t_state;

    localparam int unsigned VALUE_W = 32;
    localparam logic [VALUE_W-1:0] VMAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VMIN = 32'h8000_0000;
endpackage

[hdl/rpn_cell.sv]
// One stack cell: holds one operand, shifts toward its upper or lower neighbor.
// Depends on rpn_pkg.
module rpn_cell (
    input  logic                  i_clk,
    input  rpn_pkg::t_shift       i_shift,
    input  logic [31:0]           i_from_up,   // neighbor nearer the top
    input  logic [31:0]           i_from_dn,   // neighbor nearer the bottom
    input  logic                  i_load,
    input  logic [31:0]           i_load_val,
    output logic [31:0]           o_value
);
    import rpn_pkg::*;
    logic [31:0] r_value;
    logic [31:0] n_value;

    // cell 0 is the top of stack; push and rotate move data deeper, pop moves it up
    always_comb begin
        n_value = r_value;
        case (i_shift)
            SH_PUSH: n_value = i_from_up;
            SH_POP:  n_value = i_from_dn;
            SH_ROT:  n_value = i_from_up;
            default: n_value = r_value;
        endcase
        if (i_load) n_value = i_load_val;
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
endmodule

[hdl/rpn_alu.sv]
// Arithmetic unit: direct add/sub; multiply and restoring divide run while busy.
// Depends on rpn_pkg.
module rpn_alu #(
    parameter int FRACTION_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  rpn_pkg::t_kind i_kind,
    input  logic [31:0]  i_left,
    input  logic [31:0]  i_right,
    output logic         o_done,
    output logic [31:0]  o_result,
    output logic         o_sat
);
    import rpn_pkg::*;
    localparam int QW = 32 + FRACTION_BITS;   // dividend magnitude width
    localparam int CW = $clog2(QW + 2);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    t_kind         r_kind;
    logic          r_neg;
    logic [31:0]   r_dvs;        // divisor magnitude
    logic [QW-1:0] r_quo;        // dividend shifts out, quotient shifts in
    logic [32:0]   r_rem;
    logic [63:0]   r_prod;
    logic          r_done;
    logic [31:0]   r_res;
    logic          r_sat;
    logic [CW-1:0] n_cnt;

    logic signed [32:0] s_sum;
    logic signed [63:0] s_prodq;
    logic [QW-1:0]      s_absl;
    logic [32:0]        s_trial;
    logic [32:0]        s_remsh;
    logic [QW:0]        s_mag;

    assign s_sum = (i_kind == K_SUB)
                 ? ($signed({i_left[31], i_left}) - $signed({i_right[31], i_right}))
                 : ($signed({i_left[31], i_left}) + $signed({i_right[31], i_right}));
    assign s_absl = i_left[31] ? QW'(-{{(QW-32){1'b1}}, i_left}) : QW'(i_left);
    assign s_remsh = {r_rem[31:0], r_quo[QW-1]};
    assign s_trial = s_remsh - {1'b0, r_dvs};
    assign n_cnt = r_cnt - 1'b1;
    // truncate toward zero: arithmetic shift, plus one when negative with lost bits
    assign s_prodq = ($signed(r_prod) >>> FRACTION_BITS)
        + ((r_prod[63] && (FRACTION_BITS > 0) &&
            ((r_prod & ((64'd1 << FRACTION_BITS) - 64'd1)) != 64'd0)) ? 64'sd1 : 64'sd0);
    assign s_mag = {1'b0, r_quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_kind <= i_kind;
                case (i_kind)
                    K_ADD, K_SUB: begin
                        r_done <= 1'b1;
                        r_sat  <= (s_sum[32] != s_sum[31]);
                        r_res  <= (s_sum[32] != s_sum[31])
                                  ? (s_sum[32] ? VMIN : VMAX) : s_sum[31:0];
                    end
                    K_MUL: begin
                        r_busy <= 1'b1;
                        r_cnt  <= CW'(1);
                        r_prod <= 64'($signed(i_left) * $signed(i_right));
                    end
                    default: begin
                        if (i_right == 32'd0) begin
                            r_done <= 1'b1;
                            r_sat  <= 1'b1;
                            r_res  <= i_left[31] ? VMIN
                                    : ((i_left == 32'd0) ? 32'd0 : VMAX);
                        end else begin
                            r_busy <= 1'b1;
                            r_cnt  <= CW'(QW);
                            r_neg  <= i_left[31] ^ i_right[31];
                            r_dvs  <= i_right[31] ? (~i_right + 32'd1) : i_right;
                            r_quo  <= s_absl << FRACTION_BITS;
                            r_rem  <= '0;
                        end
                    end
                endcase
            end else if (r_busy) begin
                if (r_kind == K_MUL) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_sat  <= (s_prodq > 64'sh7FFF_FFFF) || (s_prodq < -64'sh8000_0000);
                    r_res  <= (s_prodq > 64'sh7FFF_FFFF) ? VMAX
                            : (s_prodq < -64'sh8000_0000) ? VMIN : s_prodq[31:0];
                end else if (r_cnt != '0) begin
                    // one quotient bit per cycle
                    r_cnt <= n_cnt;
                    if (!s_trial[32]) begin
                        r_rem <= s_trial;
                        r_quo <= {r_quo[QW-2:0], 1'b1};
                    end else begin
                        r_rem <= s_remsh;
                        r_quo <= {r_quo[QW-2:0], 1'b0};
                    end
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (r_neg) begin
                        r_sat <= s_mag > (QW+1)'(32'h8000_0000);
                        r_res <= (s_mag > (QW+1)'(32'h8000_0000)) ? VMIN
                               : 32'(~r_quo + 1'b1);
                    end else begin
                        r_sat <= s_mag > (QW+1)'(32'h7FFF_FFFF);
                        r_res <= (s_mag > (QW+1)'(32'h7FFF_FFFF)) ? VMAX : r_quo[31:0];
                    end
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;
    assign o_sat    = r_sat;
endmodule

[hdl/rpn_stack_calculator.sv]
// Top level of the RPN stack calculator: sequencer, cell row and arithmetic unit.
// Depends on rpn_pkg, rpn_cell, rpn_alu.
//
// One token per input beat, one item at a time. The stack is a row of
// STACK_DEPTH cells with the top in cell 0; push and pop shift the whole row
// together. Divide uses a restoring divider that yields one quotient bit per
// cycle. Print of n entries: one rotation brings the bottom entry to the
// top, then each result beat but the last rotates the live stack once more, so
// the stack is back in place after. A result stall holds the sequencer until
// the result beat is taken.
module rpn_stack_calculator #(
    parameter int STACK_DEPTH   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] operand_value
    input  logic [2:0]  s_axis_tuser,   // [2:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] result_value, [36:32] depth
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    output logic        m_axis_tlast
);
    import rpn_pkg::*;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    t_state        r_state, n_state;
    t_kind         r_kind;
    logic [DW-1:0] r_cnt;
    logic [DW-1:0] r_idx;      // print: beats still to send after the current one
    logic          r_pre;      // print: rotating the bottom entry to the top
    logic [31:0]   r_val;
    t_status       r_stat;
    logic [DW-1:0] r_odep;
    logic          r_olast;

    t_shift        s_shift;
    logic          s_load;
    logic [31:0]   s_loadv;
    logic [31:0]   s_cell [STACK_DEPTH];
    logic [AW-1:0] s_bot_idx;
    logic          s_alu_start;
    logic          s_alu_done;
    logic [31:0]   s_alu_res;
    logic          s_alu_sat;
    logic          s_acc, s_oacc;

    assign s_acc  = s_axis_tvalid && s_axis_tready;
    assign s_oacc = m_axis_tvalid && m_axis_tready;
    assign s_bot_idx = AW'(r_cnt - 1'b1);

    // cell row: cell 0 top; rotation carries the bottom of the live stack to the top
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [31:0] s_up, s_dn;
        logic        s_ld;
        if (g == 0) begin : g_top
            assign s_up = s_cell[s_bot_idx];
        end else begin : g_mid
            assign s_up = s_cell[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_bot
            assign s_dn = s_cell[0];
        end else begin : g_nb
            assign s_dn = s_cell[g+1];
        end
        assign s_ld = s_load && (g == 0);
        rpn_cell u_cell (
            .i_clk(i_clk), .i_shift((s_shift == SH_ROT && DW'(g) >= r_cnt) ? SH_HOLD
                                    : s_shift),
            .i_from_up(s_up), .i_from_dn(s_dn),
            .i_load(s_ld), .i_load_val(s_loadv), .o_value(s_cell[g])
        );
    end

    rpn_alu #(.FRACTION_BITS(FRACTION_BITS)) u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(s_alu_start), .i_kind(r_kind),
        .i_left(s_cell[1]), .i_right(s_cell[0]),
        .o_done(s_alu_done), .o_result(s_alu_res), .o_sat(s_alu_sat)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (s_acc) begin
                case (t_kind'(s_axis_tuser))
                    K_ADD, K_SUB, K_MUL, K_DIV:
                        n_state = (r_cnt < DW'(2)) ? S_OUT : S_MUL;
                    K_PRINT: n_state = (r_cnt == '0) ? S_OUT : S_PRINT;
                    default: n_state = S_OUT;
                endcase
            end
            S_MUL:   n_state = S_DIV;
            S_DIV:   if (s_alu_done) n_state = S_WRITE;
            S_WRITE: n_state = S_OUT;
            S_PRINT: if (!r_pre && s_oacc && r_idx == '0) n_state = S_IDLE;
            S_OUT:   if (s_oacc) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_shift = SH_HOLD;
        s_load = 1'b0;
        s_loadv = s_alu_res;
        s_alu_start = (r_state == S_MUL);
        s_axis_tready = (r_state == S_IDLE);
        m_axis_tvalid = (r_state == S_OUT) || (r_state == S_PRINT && !r_pre);
        case (r_state)
            S_DIV: if (s_alu_done) s_shift = SH_POP;
            S_WRITE: s_load = 1'b1;
            S_PRINT: if (r_pre || (s_oacc && r_idx != '0)) s_shift = SH_ROT;
            default: s_shift = SH_HOLD;
        endcase
        if (r_state == S_IDLE && s_acc && t_kind'(s_axis_tuser) == K_PUSH
            && r_cnt < DW'(STACK_DEPTH)) begin
            s_load = 1'b1;
            s_shift = SH_PUSH;
            s_loadv = s_axis_tdata[31:0];
        end
    end

    // control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_pre   <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (s_acc) begin
                    r_kind  <= t_kind'(s_axis_tuser);
                    r_olast <= 1'b1;
                    r_stat  <= ST_OK;
                    r_odep  <= r_cnt;
                    r_val   <= (r_cnt == '0) ? 32'd0 : s_cell[0];
                    case (t_kind'(s_axis_tuser))
                        K_PUSH: begin
                            if (r_cnt < DW'(STACK_DEPTH)) begin
                                r_cnt  <= r_cnt + 1'b1;
                                r_odep <= r_cnt + 1'b1;
                                r_val  <= s_axis_tdata[31:0];
                            end else begin
                                r_stat <= ST_OVERFLOW;
                            end
                        end
                        K_ADD, K_SUB, K_MUL, K_DIV:
                            if (r_cnt < DW'(2)) r_stat <= ST_UNDERFLOW;
                        K_PRINT: begin
                            if (r_cnt == '0) begin
                                r_stat <= ST_EMPTY;
                            end else begin
                                r_idx <= r_cnt - 1'b1;
                                r_pre <= 1'b1;
                            end
                        end
                        K_CLEAR: begin
                            r_cnt <= '0;
                            r_odep <= '0;
                            r_val <= 32'd0;
                        end
                        default: r_stat <= ST_BADOP;
                    endcase
                end
                S_DIV: if (s_alu_done) begin
                    r_cnt  <= r_cnt - 1'b1;
                    r_odep <= r_cnt - 1'b1;
                    r_val  <= s_alu_res;
                    r_stat <= s_alu_sat ? ST_SAT : ST_OK;
                end
                S_PRINT: begin
                    // one rotation brings the bottom up, then count down the beats
                    if (r_pre) begin
                        r_pre <= 1'b0;
                    end else if (s_oacc) begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tdata = (r_state == S_PRINT)
        ? {3'd0, 5'(r_cnt), s_cell[0]} : {3'd0, 5'(r_odep), r_val};
    assign m_axis_tuser = (r_state == S_PRINT) ? ST_OK : r_stat;
    assign m_axis_tlast = (r_state == S_PRINT) ? (r_idx == '0) : r_olast;
endmodule

[test/rpn_result_checker.sv]
// Checker for the RPN stack calculator: tracks its own stack, predicts result beats.
// Depends on rpn_pkg; instantiated beside the DUT by tb_rpn_stack_calculator.
module rpn_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] operand_value
    input  logic [2:0]  s_axis_tuser,   // [2:0] kind
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // [31:0] result_value, [36:32] depth
    input  logic [2:0]  m_axis_tuser,   // [2:0] status
    input  logic        m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    import rpn_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        t_status     status;
        logic [4:0]  depth;
        logic        last;
    } t_result;

    localparam int DEPTH_MAX = 16;
    localparam int FRAC      = 16;
    localparam longint QMAX  = 64'sd2147483647;
    localparam longint QMIN  = -64'sd2147483648;

    longint  model_stack [DEPTH_MAX];
    int      model_count;
    t_result expected_q [$];

    function automatic longint clamp_q(longint v, ref bit sat);
        if (v > QMAX) begin
            sat = 1;
            return QMAX;
        end
        if (v < QMIN) begin
            sat = 1;
            return QMIN;
        end
        return v;
    endfunction

    // arithmetic of one operator; SV division truncates toward zero
    function automatic longint calc_op(t_kind k, longint a, longint b, ref bit sat);
        longint r;
        case (k)
            K_ADD: r = a + b;
            K_SUB: r = a - b;
            K_MUL: r = (a * b) / (64'sd1 << FRAC);
            default: begin
                if (b == 0) begin
                    sat = 1;
                    return (a > 0) ? QMAX : (a < 0) ? QMIN : 0;
                end
                r = (a * (64'sd1 << FRAC)) / b;
            end
        endcase
        return clamp_q(r, sat);
    endfunction

    function automatic void queue_result(longint v, t_status st, int d, bit l);
        t_result r;
        r.value  = v[31:0];
        r.status = st;
        r.depth  = d[4:0];
        r.last   = l;
        expected_q.push_back(r);
    endfunction

    // advance the model by one token
    task automatic predict_token(t_kind k, logic [31:0] operand);
        t_status st;
        bit      sat;
        st  = ST_OK;
        sat = 0;
        case (k)
            K_PUSH: begin
                if (model_count >= DEPTH_MAX) st = ST_OVERFLOW;
                else begin
                    model_stack[model_count] = longint'(signed'(operand));
                    model_count++;
                end
            end
            K_ADD, K_SUB, K_MUL, K_DIV: begin
                if (model_count < 2) st = ST_UNDERFLOW;
                else begin
                    model_stack[model_count-2] = calc_op(k, model_stack[model_count-2],
                                                         model_stack[model_count-1], sat);
                    model_count--;
                    if (sat) st = ST_SAT;
                end
            end
            K_PRINT: begin
                if (model_count == 0) queue_result(0, ST_EMPTY, 0, 1);
                else
                    for (int i = 0; i < model_count; i++)
                        queue_result(model_stack[i], ST_OK, model_count,
                                     i == model_count - 1);
                return;
            end
            K_CLEAR: model_count = 0;
            default: st = ST_BADOP;
        endcase
        queue_result(model_count ? model_stack[model_count-1] : 0, st, model_count, 1);
    endtask

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            model_count    <= 0;
            o_fail_count   <= 0;
            o_result_count <= 0;
            o_pending      <= 0;
            expected_q.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_token(t_kind'(s_axis_tuser), s_axis_tdata[31:0]);
            if (m_axis_tvalid && m_axis_tready) begin
                o_result_count <= o_result_count + 1;
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected result beat value=%h status=%0d",
                                 m_axis_tdata[31:0], m_axis_tuser);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (m_axis_tdata[31:0] !== exp_r.value || m_axis_tuser !== exp_r.status
                        || m_axis_tdata[36:32] !== exp_r.depth
                        || m_axis_tlast !== exp_r.last) begin
                        if (o_fail_count < 10)
                            $display({"ERROR: exp v=%h st=%0d d=%0d l=%0d",
                                      " got v=%h st=%0d d=%0d l=%0d"},
                                     exp_r.value, exp_r.status, exp_r.depth, exp_r.last,
                                     m_axis_tdata[31:0], m_axis_tuser,
                                     m_axis_tdata[36:32], m_axis_tlast);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_q.size();
        end
    end
endmodule

[test/tb_rpn_stack_calculator.sv]
// Testbench top for the RPN stack calculator: clock, reset, token stimulus, verdict.
// Depends on rpn_pkg, rpn_stack_calculator and rpn_result_checker.
module tb_rpn_stack_calculator;
    import rpn_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] operand_value
    logic [2:0]  s_axis_tuser;   // [2:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [31:0] result_value, [36:32] depth
    logic [2:0]  m_axis_tuser;   // [2:0] status
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    int result_count;
    int send_idle_pct;
    int recv_stall_pct;
    int token_count;
    int idle_cycles;

    rpn_stack_calculator u_dut (.*);

    rpn_result_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // receiver backpressure
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog: cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: watchdog expired");
            $display("tb_rpn_stack_calculator failed");
            $finish;
        end
    end

    // drive one token and hold it until accepted; tvalid stays up for the next token
    task automatic send_token(t_kind k, logic [31:0] operand);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= operand;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        token_count++;
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3: return 32'($signed($urandom_range(2000)) - 1000) << 16;
            4: return $urandom_range(255) - 128;
            default: return $urandom;
        endcase
    endfunction

    // mostly well-formed: operators only once two operands sit on the stack
    task automatic random_tokens(int n);
        int depth_est;
        t_kind k;
        depth_est = 0;
        send_token(K_CLEAR, 0);
        repeat (n) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6: k = K_PUSH;
                7, 8:   k = K_ADD;
                9, 10:  k = K_SUB;
                11, 12: k = K_MUL;
                13, 14: k = K_DIV;
                15, 16: k = K_PRINT;
                17:     k = K_CLEAR;
                18:     k = K_BAD;
                default: k = t_kind'($urandom_range(7));
            endcase
            if (k inside {K_ADD, K_SUB, K_MUL, K_DIV} && depth_est < 2
                && $urandom_range(9) != 0)
                k = K_PUSH;
            send_token(k, pick_operand());
            case (k)
                K_PUSH: if (depth_est < 16) depth_est++;
                K_ADD, K_SUB, K_MUL, K_DIV: if (depth_est >= 2) depth_est--;
                K_CLEAR: depth_est = 0;
                default: ;
            endcase
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = K_PUSH;
        m_axis_tready  = 1'b1;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        token_count    = 0;
        idle_cycles    = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-stack cases, extremes, saturation, divide by zero, full stack
        send_token(K_PRINT, 0);
        send_token(K_ADD, 0);
        send_token(K_BAD, 32'hFFFF_FFFF);
        send_token(K_PUSH, 32'h7FFF_FFFF);
        send_token(K_PUSH, 32'h7FFF_FFFF);
        send_token(K_ADD, 0);
        send_token(K_PUSH, 32'h8000_0000);
        send_token(K_MUL, 0);
        send_token(K_PUSH, 32'd0);
        send_token(K_DIV, 0);
        send_token(K_PUSH, 32'hFFFF_0000);
        send_token(K_PUSH, 32'd0);
        send_token(K_DIV, 0);
        send_token(K_PUSH, 32'h0003_0000);
        send_token(K_SUB, 0);
        send_token(K_PUSH, 32'h0002_0000);
        send_token(K_DIV, 0);
        send_token(K_PRINT, 0);
        send_token(K_CLEAR, 0);
        for (int i = 0; i < 17; i++) send_token(K_PUSH, $urandom);
        send_token(K_PRINT, 0);

        // random tokens across the idling phases
        send_idle_pct = 0;  recv_stall_pct = 0;  random_tokens(100);
        send_idle_pct = 88; recv_stall_pct = 0;  random_tokens(90);
        send_idle_pct = 0;  recv_stall_pct = 88; random_tokens(90);
        send_idle_pct = 16; recv_stall_pct = 16; random_tokens(100);
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Covered %0d tokens (all kinds, full and empty stack, %s",
                 token_count, "saturation, divide by zero)");
        $display("and %0d result beats under sender idling and receiver stalls.", result_count);
        if (fail_count == 0)
            $display("tb_rpn_stack_calculator passed");
        else
            $display("tb_rpn_stack_calculator failed");
        $finish;
    end
endmodule

[filelist.f]
hdl/rpn_pkg.sv
hdl/rpn_cell.sv
hdl/rpn_alu.sv
hdl/rpn_stack_calculator.sv
test/rpn_result_checker.sv
test/tb_rpn_stack_calculator.sv
